FILE: hw/rtl/tcdfl_pkg.sv
// Shared types and constants for the two-channel distance frame link.
// Used by the front end, queue, back end and top level; no dependencies.
package tcdfl_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int FRAME_LEN   = 5;

  localparam logic [7:0]  HEADER_RESET  = 8'hAA;
  localparam logic [7:0]  ADDR_A_RESET  = 8'd64;
  localparam logic [7:0]  ADDR_B_RESET  = 8'd65;
  localparam logic [15:0] TIMEOUT_RESET = 16'd500;
  localparam logic [15:0] AGE_MAX       = 16'hFFFF;

  typedef enum logic [1:0] {
    CMD_BYTE     = 2'd0,
    CMD_TICK     = 2'd1,
    CMD_SEND     = 2'd2,
    CMD_LINE_ERR = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    REG_HEADER  = 3'd0,
    REG_ADDR_A  = 3'd1,
    REG_ADDR_B  = 3'd2,
    REG_TIMEOUT = 3'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    POS_HEADER = 3'd0,
    POS_ADDR   = 3'd1,
    POS_LOW    = 3'd2,
    POS_HIGH   = 3'd3,
    POS_CHECK  = 3'd4
  } parse_pos_t;

  typedef enum logic [2:0] {
    BYTE_HEADER = 3'd0,
    BYTE_ADDR   = 3'd1,
    BYTE_LOW    = 3'd2,
    BYTE_HIGH   = 3'd3,
    BYTE_CHECK  = 3'd4
  } tx_pos_t;

  typedef struct packed {
    logic [7:0]  header_value;
    logic [7:0]  address_a;
    logic [7:0]  address_b;
    logic [15:0] timeout_ticks;
  } cfg_t;

  // One unit of output work: a status snapshot or a frame send.
  typedef struct packed {
    logic        is_send;
    logic        send_a;
    logic        send_b;
    logic        accepted;
    logic [15:0] distance_a;
    logic [15:0] distance_b;
    logic        online_a;
    logic        online_b;
  } job_t;

endpackage

FILE: hw/rtl/tcdfl_front.sv
// Front end: frame parser and per-channel distance/age/online state.
// Turns each accepted item into one job. Depends on tcdfl_pkg.
module tcdfl_front (
  input  logic              clk,
  input  logic              rst_n,
  input  tcdfl_pkg::cfg_t   cfg,
  input  logic              accept,
  input  logic [1:0]        command,
  input  logic [7:0]        data_byte,
  output logic              job_push,
  output tcdfl_pkg::job_t   job
);

  tcdfl_pkg::parse_pos_t pos_r, pos_nxt;
  logic [7:0]  addr_r, addr_nxt;
  logic [7:0]  low_r, low_nxt;
  logic [7:0]  high_r, high_nxt;
  logic [7:0]  xor_r, xor_nxt;
  logic [15:0] dist_a_r, dist_a_nxt;
  logic [15:0] dist_b_r, dist_b_nxt;
  logic        alive_a_r, alive_a_nxt;
  logic        alive_b_r, alive_b_nxt;
  logic        pend_a_r, pend_a_nxt;
  logic        pend_b_r, pend_b_nxt;
  logic [15:0] age_a_r, age_a_nxt;
  logic [15:0] age_b_r, age_b_nxt;
  logic        accepted;
  tcdfl_pkg::cmd_t cmd;

  assign cmd = tcdfl_pkg::cmd_t'(command);

  always_comb begin
    pos_nxt     = pos_r;
    addr_nxt    = addr_r;
    low_nxt     = low_r;
    high_nxt    = high_r;
    xor_nxt     = xor_r;
    dist_a_nxt  = dist_a_r;
    dist_b_nxt  = dist_b_r;
    alive_a_nxt = alive_a_r;
    alive_b_nxt = alive_b_r;
    pend_a_nxt  = pend_a_r;
    pend_b_nxt  = pend_b_r;
    age_a_nxt   = age_a_r;
    age_b_nxt   = age_b_r;
    accepted    = 1'b0;
    if (accept) begin
      unique case (cmd)
        tcdfl_pkg::CMD_BYTE: begin
          unique case (pos_r)
            tcdfl_pkg::POS_HEADER: begin
              if (data_byte == cfg.header_value) begin
                xor_nxt = data_byte;
                pos_nxt = tcdfl_pkg::POS_ADDR;
              end
            end
            tcdfl_pkg::POS_ADDR: begin
              addr_nxt = data_byte;
              xor_nxt  = xor_r ^ data_byte;
              pos_nxt  = tcdfl_pkg::POS_LOW;
            end
            tcdfl_pkg::POS_LOW: begin
              low_nxt = data_byte;
              xor_nxt = xor_r ^ data_byte;
              pos_nxt = tcdfl_pkg::POS_HIGH;
            end
            tcdfl_pkg::POS_HIGH: begin
              high_nxt = data_byte;
              xor_nxt  = xor_r ^ data_byte;
              pos_nxt  = tcdfl_pkg::POS_CHECK;
            end
            default: begin
              // check byte; channel A wins when both addresses match
              if (data_byte == xor_r) begin
                if (addr_r == cfg.address_a) begin
                  dist_a_nxt  = {high_r, low_r};
                  alive_a_nxt = 1'b1;
                  pend_a_nxt  = 1'b1;
                  age_a_nxt   = '0;
                  accepted    = 1'b1;
                end else if (addr_r == cfg.address_b) begin
                  dist_b_nxt  = {high_r, low_r};
                  alive_b_nxt = 1'b1;
                  pend_b_nxt  = 1'b1;
                  age_b_nxt   = '0;
                  accepted    = 1'b1;
                end
              end
              pos_nxt = tcdfl_pkg::POS_HEADER;
            end
          endcase
        end
        tcdfl_pkg::CMD_TICK: begin
          age_a_nxt = (age_a_r == tcdfl_pkg::AGE_MAX) ? age_a_r : age_a_r + 16'd1;
          age_b_nxt = (age_b_r == tcdfl_pkg::AGE_MAX) ? age_b_r : age_b_r + 16'd1;
          if (alive_a_r && (age_a_nxt > cfg.timeout_ticks)) alive_a_nxt = 1'b0;
          if (alive_b_r && (age_b_nxt > cfg.timeout_ticks)) alive_b_nxt = 1'b0;
        end
        tcdfl_pkg::CMD_SEND: begin
          pend_a_nxt = 1'b0;
          pend_b_nxt = 1'b0;
        end
        tcdfl_pkg::CMD_LINE_ERR: begin
          pos_nxt = tcdfl_pkg::POS_HEADER;
        end
        default: ;
      endcase
    end
  end

  // Snapshot the status as it stands after this item's update
  always_comb begin
    job_push       = accept;
    job.is_send    = (cmd == tcdfl_pkg::CMD_SEND);
    job.send_a     = pend_a_r;
    job.send_b     = pend_b_r;
    job.accepted   = accepted;
    job.distance_a = dist_a_nxt;
    job.distance_b = dist_b_nxt;
    job.online_a   = alive_a_nxt;
    job.online_b   = alive_b_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= tcdfl_pkg::POS_HEADER;
      addr_r    <= '0;
      low_r     <= '0;
      high_r    <= '0;
      xor_r     <= '0;
      dist_a_r  <= '0;
      dist_b_r  <= '0;
      alive_a_r <= 1'b0;
      alive_b_r <= 1'b0;
      pend_a_r  <= 1'b0;
      pend_b_r  <= 1'b0;
      age_a_r   <= '0;
      age_b_r   <= '0;
    end else begin
      pos_r     <= pos_nxt;
      addr_r    <= addr_nxt;
      low_r     <= low_nxt;
      high_r    <= high_nxt;
      xor_r     <= xor_nxt;
      dist_a_r  <= dist_a_nxt;
      dist_b_r  <= dist_b_nxt;
      alive_a_r <= alive_a_nxt;
      alive_b_r <= alive_b_nxt;
      pend_a_r  <= pend_a_nxt;
      pend_b_r  <= pend_b_nxt;
      age_a_r   <= age_a_nxt;
      age_b_r   <= age_b_nxt;
    end
  end

endmodule

FILE: hw/rtl/tcdfl_fifo.sv
// Short job queue between front end and back end.
// Register based, one write and one read per cycle. Depends on tcdfl_pkg.
module tcdfl_fifo #(
  parameter int Depth = tcdfl_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  tcdfl_pkg::job_t   push_data,
  input  logic              pop,
  output tcdfl_pkg::job_t   head,
  output logic              full,
  output logic              empty
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  tcdfl_pkg::job_t   mem_r [Depth];
  logic [PtrW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]   cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full    = (cnt_r == FullCnt);
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + 1'b1;
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + 1'b1;
    if (do_push && !do_pop)      cnt_nxt = cnt_r + 1'b1;
    else if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

FILE: hw/rtl/tcdfl_back.sv
// Back end: expands jobs into result items and holds them in the output register.
// A send job becomes up to two 5-byte frames, channel B first. Depends on tcdfl_pkg.
module tcdfl_back (
  input  logic              clk,
  input  logic              rst_n,
  input  tcdfl_pkg::cfg_t   cfg,
  input  tcdfl_pkg::job_t   head,
  input  logic              q_empty,
  output logic              q_pop,
  input  logic              out_pop,
  output logic              out_empty,
  output logic              out_kind,
  output logic [7:0]        out_tx_byte,
  output logic              out_last,
  output logic              out_frame_accepted,
  output logic [15:0]       out_distance_a,
  output logic [15:0]       out_distance_b,
  output logic              out_online_a,
  output logic              out_online_b
);

  tcdfl_pkg::job_t    cur_r, cur_nxt;
  logic               cur_valid_r, cur_valid_nxt;
  tcdfl_pkg::tx_pos_t tx_pos_r, tx_pos_nxt;
  logic               phase_a_r, phase_a_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               kind_r, kind_nxt;
  logic [7:0]         byte_r, byte_nxt;
  logic               last_r, last_nxt;
  logic               acc_r, acc_nxt;
  logic [15:0]        dist_a_r, dist_a_nxt;
  logic [15:0]        dist_b_r, dist_b_nxt;
  logic               onl_a_r, onl_a_nxt;
  logic               onl_b_r, onl_b_nxt;

  logic               slot_free, advance, finish, frames, chan_b;
  logic [7:0]         ch_addr;
  logic [15:0]        ch_dist;

  assign slot_free = !out_valid_r || out_pop;
  assign advance   = cur_valid_r && slot_free;
  assign frames    = cur_r.is_send && (cur_r.send_a || cur_r.send_b);
  assign chan_b    = cur_r.send_b && !phase_a_r;
  assign ch_addr   = chan_b ? cfg.address_b : cfg.address_a;
  assign ch_dist   = chan_b ? cur_r.distance_b : cur_r.distance_a;
  assign finish    = advance && (!frames ||
                     ((tx_pos_r == tcdfl_pkg::BYTE_CHECK) && (!chan_b || !cur_r.send_a)));
  assign q_pop     = !q_empty && (!cur_valid_r || finish);

  always_comb begin
    cur_nxt       = cur_r;
    cur_valid_nxt = cur_valid_r;
    tx_pos_nxt    = tx_pos_r;
    phase_a_nxt   = phase_a_r;
    out_valid_nxt = out_valid_r && !out_pop;
    kind_nxt      = kind_r;
    byte_nxt      = byte_r;
    last_nxt      = last_r;
    acc_nxt       = acc_r;
    dist_a_nxt    = dist_a_r;
    dist_b_nxt    = dist_b_r;
    onl_a_nxt     = onl_a_r;
    onl_b_nxt     = onl_b_r;

    if (advance) begin
      out_valid_nxt = 1'b1;
      dist_a_nxt    = cur_r.distance_a;
      dist_b_nxt    = cur_r.distance_b;
      onl_a_nxt     = cur_r.online_a;
      onl_b_nxt     = cur_r.online_b;
      last_nxt      = finish;
      if (!frames) begin
        kind_nxt = 1'b0;
        byte_nxt = '0;
        acc_nxt  = cur_r.accepted;
      end else begin
        kind_nxt = 1'b1;
        acc_nxt  = 1'b0;
        unique case (tx_pos_r)
          tcdfl_pkg::BYTE_HEADER: byte_nxt = cfg.header_value;
          tcdfl_pkg::BYTE_ADDR:   byte_nxt = ch_addr;
          tcdfl_pkg::BYTE_LOW:    byte_nxt = ch_dist[7:0];
          tcdfl_pkg::BYTE_HIGH:   byte_nxt = ch_dist[15:8];
          default: byte_nxt = cfg.header_value ^ ch_addr ^ ch_dist[7:0] ^ ch_dist[15:8];
        endcase
        if (tx_pos_r == tcdfl_pkg::BYTE_CHECK) begin
          tx_pos_nxt  = tcdfl_pkg::BYTE_HEADER;
          phase_a_nxt = 1'b1;
        end else begin
          tx_pos_nxt = tcdfl_pkg::tx_pos_t'(tx_pos_r + 3'd1);
        end
      end
      if (finish) cur_valid_nxt = 1'b0;
    end

    // load the next job the cycle the current one retires
    if (q_pop) begin
      cur_nxt       = head;
      cur_valid_nxt = 1'b1;
      tx_pos_nxt    = tcdfl_pkg::BYTE_HEADER;
      phase_a_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      tx_pos_r    <= tcdfl_pkg::BYTE_HEADER;
      phase_a_r   <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      out_valid_r <= out_valid_nxt;
      tx_pos_r    <= tx_pos_nxt;
      phase_a_r   <= phase_a_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r    <= cur_nxt;
    kind_r   <= kind_nxt;
    byte_r   <= byte_nxt;
    last_r   <= last_nxt;
    acc_r    <= acc_nxt;
    dist_a_r <= dist_a_nxt;
    dist_b_r <= dist_b_nxt;
    onl_a_r  <= onl_a_nxt;
    onl_b_r  <= onl_b_nxt;
  end

  assign out_empty          = !out_valid_r;
  assign out_kind           = kind_r;
  assign out_tx_byte        = byte_r;
  assign out_last           = last_r;
  assign out_frame_accepted = acc_r;
  assign out_distance_a     = dist_a_r;
  assign out_distance_b     = dist_b_r;
  assign out_online_a       = onl_a_r;
  assign out_online_b       = onl_b_r;

endmodule

FILE: hw/rtl/two_channel_distance_frame_link.sv
// Top level of the two-channel distance frame link: config registers,
// front end, job queue and back end. Depends on tcdfl_pkg and the tcdfl_* modules.
//
//   channel   ports                       transfer when
//   -------   -------------------------   --------------------------
//   input     in_push / in_full           in_push && !in_full
//   result    out_empty / out_pop         out_pop && !out_empty
//   config    cfg_valid / cfg_ready       cfg_valid && cfg_ready
//
// One item per cycle enters the front end while in_full is low; its state
// updates at that edge. Unless the result port stalls, the back end emits
// one result per cycle: one for a byte, tick or line error, one, 5 or 10 for a send.
// in_full rises when the job queue (QueueDepth entries) fills, either behind
// a stalled result port or while a send request's frames hold the back end.
// Reset is synchronous and clears all control state.
module two_channel_distance_frame_link #(
  parameter int QueueDepth = tcdfl_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_command,
  input  logic [7:0]  in_data_byte,
  output logic        out_empty,
  input  logic        out_pop,
  output logic        out_kind,
  output logic [7:0]  out_tx_byte,
  output logic        out_last,
  output logic        out_frame_accepted,
  output logic [15:0] out_distance_a,
  output logic [15:0] out_distance_b,
  output logic        out_online_a,
  output logic        out_online_b,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  tcdfl_pkg::cfg_t cfg_r, cfg_nxt;
  tcdfl_pkg::job_t job, head;
  logic            job_push, q_pop, q_empty, accept;

  assign cfg_ready = 1'b1;
  assign accept    = in_push && !in_full;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (tcdfl_pkg::reg_idx_t'(cfg_index))
        tcdfl_pkg::REG_HEADER:  cfg_nxt.header_value  = cfg_data[7:0];
        tcdfl_pkg::REG_ADDR_A:  cfg_nxt.address_a     = cfg_data[7:0];
        tcdfl_pkg::REG_ADDR_B:  cfg_nxt.address_b     = cfg_data[7:0];
        tcdfl_pkg::REG_TIMEOUT: cfg_nxt.timeout_ticks = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header_value  <= tcdfl_pkg::HEADER_RESET;
      cfg_r.address_a     <= tcdfl_pkg::ADDR_A_RESET;
      cfg_r.address_b     <= tcdfl_pkg::ADDR_B_RESET;
      cfg_r.timeout_ticks <= tcdfl_pkg::TIMEOUT_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  tcdfl_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .accept    (accept),
    .command   (in_command),
    .data_byte (in_data_byte),
    .job_push  (job_push),
    .job       (job)
  );

  tcdfl_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .push_data (job),
    .pop       (q_pop),
    .head      (head),
    .full      (in_full),
    .empty     (q_empty)
  );

  tcdfl_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .head               (head),
    .q_empty            (q_empty),
    .q_pop              (q_pop),
    .out_pop            (out_pop),
    .out_empty          (out_empty),
    .out_kind           (out_kind),
    .out_tx_byte        (out_tx_byte),
    .out_last           (out_last),
    .out_frame_accepted (out_frame_accepted),
    .out_distance_a     (out_distance_a),
    .out_distance_b     (out_distance_b),
    .out_online_a       (out_online_a),
    .out_online_b       (out_online_b)
  );

endmodule

FILE: hw/rtl/tcdfl_checker.sv
// Port-level checks for two_channel_distance_frame_link, attached by bind.
// Sees only the top-level ports; no package dependency.
module tcdfl_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_empty,
  input logic       out_pop,
  input logic       out_kind,
  input logic [7:0] out_tx_byte,
  input logic       out_last,
  input logic       out_frame_accepted
);

  // a status snapshot is always the only result of its item
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_kind) |-> out_last)
    else $error("status result without last");

  a_frame_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_kind) |-> !out_frame_accepted)
    else $error("frame byte flagged as accepted frame");

  a_status_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_kind) |-> (out_tx_byte == 8'd0))
    else $error("status result carries a tx byte");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> out_empty)
    else $error("result pending right after reset");

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> !out_empty)
    else $error("waiting result dropped without transfer");

endmodule

bind two_channel_distance_frame_link tcdfl_checker u_tcdfl_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_empty          (out_empty),
  .out_pop            (out_pop),
  .out_kind           (out_kind),
  .out_tx_byte        (out_tx_byte),
  .out_last           (out_last),
  .out_frame_accepted (out_frame_accepted)
);
